/* src/poc_pkg.sv */
// Package with shared types, constants and a helper function for the pageblock classifier.
package poc_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int SEEN_DEPTH  = 64;
    localparam int BLOCK_PAGES = 512;

    localparam int TAB_AW = $clog2(TABLE_DEPTH);
    localparam int TAB_CW = $clog2(TABLE_DEPTH + 1);
    localparam int SEEN_AW = $clog2(SEEN_DEPTH);
    localparam int SEEN_CW = $clog2(SEEN_DEPTH + 1);
    localparam int BLK_CW = $clog2(BLOCK_PAGES + 1);

    localparam logic [1:0] OP_PAGE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] KIND_FREE    = 3'd1;
    localparam logic [2:0] KIND_LRU     = 3'd2;
    localparam logic [2:0] KIND_NONLRU  = 3'd3;
    localparam logic [2:0] KIND_SLAB    = 3'd4;

    localparam logic [1:0] PIN_NONE  = 2'd0;
    localparam logic [1:0] PIN_ONE   = 2'd1;
    localparam logic [1:0] PIN_TWO   = 2'd2;
    localparam logic [1:0] PIN_MANY  = 2'd3;

    localparam logic [1:0] OBST_SLAB    = 2'd0;
    localparam logic [1:0] OBST_NONSLAB = 2'd1;
    localparam logic [1:0] OBST_MOBILE  = 2'd2;

    localparam logic [9:0] LIMIT_RESET = 10'd64;

    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  page_kind;
        logic [15:0] owner_key;
        logic        owner_mobile;
        logic        block_end;
        logic [8:0]  entry_index;
    } in_item_t;

    typedef struct packed {
        logic        present;
        logic [15:0] entry_key;
        logic [39:0] page_total;
        logic [9:0]  free_total;
        logic        is_hostage;
        logic [1:0]  pin_class;
        logic [1:0]  obstacle;
        logic [31:0] block_count;
        logic [39:0] hostage_page_count;
        logic [31:0] hostage_block_count;
        logic [31:0] solo_block_count;
        logic        entry_mobile;
    } result_t;

    typedef struct packed {
        logic [15:0] key;
        logic [39:0] pages;
        logic [31:0] blocks;
        logic [39:0] hpages;
        logic [31:0] hblocks;
        logic [31:0] lone;
        logic        mobile;
    } table_entry_t;

    typedef struct packed {
        logic [15:0]       key;
        logic [TAB_AW-1:0] slot;
        logic [BLK_CW-1:0] count;
    } seen_entry_t;

    typedef struct packed {
        logic accept;
        logic count_page;
        logic idx_clr;
        logic idx_inc;
        logic seen_rd;
        logic seen_bump;
        logic seen_add;
        logic tab_rd_idx;
        logic tab_rd_slot;
        logic tab_rd_read;
        logic tab_new;
        logic tab_found;
        logic fin_start;
        logic fin_wr;
        logic emit_block;
        logic emit_read;
        logic emit_empty;
        logic clear_table;
        logic clear_block;
    } dp_cmd_t;

    typedef struct packed {
        logic is_page;
        logic is_read;
        logic is_clear;
        logic is_slab;
        logic block_end;
        logic seen_end;
        logic seen_full;
        logic seen_hit;
        logic tab_end;
        logic tab_full;
        logic tab_hit;
        logic block_valid;
        logic read_ok;
    } dp_status_t;

    function automatic logic [BLK_CW-1:0] sat_inc(input logic [BLK_CW-1:0] v);
        if (v >= BLK_CW'(BLOCK_PAGES))
            return BLK_CW'(BLOCK_PAGES);
        return v + 1'b1;
    endfunction

endpackage

/* src/pageblock_occupancy_classifier.sv */
// Top level of the pageblock occupancy classifier: controller plus datapath.
//
//   channel   signals                 handshake
//   input     start, busy, in_item    taken when start is high and busy is low
//   config    cfg_we, cfg_wdata       hostage limit written when cfg_we is high
//   result    done, result            one-cycle strobe, cannot be held off
//
// One item is handled at a time. A slab page reads and compares the seen list slot by slot
// and, on a miss, the table entry by entry, then closes the searches and may append a new
// entry; each list has its own single memory read port. A block end reads, for each cache
// seen in the block, its seen slot and its table entry and writes the entry back. The result
// strobe comes in the cycle after the last busy cycle and the receiver cannot stall it.
// Reset empties the table and the block at once.
module pageblock_occupancy_classifier
    import poc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  in_item_t   in_item,
    input  logic       cfg_we,
    input  logic [9:0] cfg_wdata,
    output logic       done,
    output result_t    result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    poc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    poc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .done      (done),
        .result    (result)
    );

endmodule

/* src/poc_ctrl.sv */
// Controller state machine that sequences searches, block finish and reads.
module poc_ctrl
    import poc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_SEEN_RD, ST_SEEN_CMP, ST_TAB_RD, ST_TAB_CMP, ST_SEEN_ADD,
        ST_BLK_CHK, ST_FIN_SRD, ST_FIN_TRD, ST_FIN_WR, ST_RESULT, ST_READ_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_page)
                begin
                    cmd.count_page = 1'b1;
                    if (status.is_slab)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next = ST_SEEN_RD;
                    end
                    else
                    begin
                        state_next = ST_BLK_CHK;
                    end
                end
                else if (status.is_read)
                begin
                    if (status.read_ok)
                    begin
                        cmd.tab_rd_read = 1'b1;
                        state_next = ST_READ_OUT;
                    end
                    else
                    begin
                        cmd.emit_empty = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    if (status.is_clear)
                    begin
                        cmd.clear_table = 1'b1;
                        cmd.clear_block = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SEEN_RD:
            begin
                if (status.seen_end)
                begin
                    if (status.seen_full)
                    begin
                        state_next = ST_BLK_CHK;
                    end
                    else
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next = ST_TAB_RD;
                    end
                end
                else
                begin
                    cmd.seen_rd = 1'b1;
                    state_next = ST_SEEN_CMP;
                end
            end
            ST_SEEN_CMP:
            begin
                if (status.seen_hit)
                begin
                    cmd.seen_bump = 1'b1;
                    state_next = ST_BLK_CHK;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = ST_SEEN_RD;
                end
            end
            ST_TAB_RD:
            begin
                if (status.tab_end)
                begin
                    if (status.tab_full)
                    begin
                        state_next = ST_BLK_CHK;
                    end
                    else
                    begin
                        cmd.tab_new = 1'b1;
                        state_next = ST_SEEN_ADD;
                    end
                end
                else
                begin
                    cmd.tab_rd_idx = 1'b1;
                    state_next = ST_TAB_CMP;
                end
            end
            ST_TAB_CMP:
            begin
                if (status.tab_hit)
                begin
                    cmd.tab_found = 1'b1;
                    state_next = ST_SEEN_ADD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = ST_TAB_RD;
                end
            end
            ST_SEEN_ADD:
            begin
                cmd.seen_add = 1'b1;
                state_next = ST_BLK_CHK;
            end
            ST_BLK_CHK:
            begin
                if (!status.block_end)
                begin
                    state_next = ST_IDLE;
                end
                else if (!status.block_valid)
                begin
                    cmd.emit_empty = 1'b1;
                    cmd.clear_block = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.fin_start = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next = ST_FIN_SRD;
                end
            end
            ST_FIN_SRD:
            begin
                if (status.seen_end)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.seen_rd = 1'b1;
                    state_next = ST_FIN_TRD;
                end
            end
            ST_FIN_TRD:
            begin
                cmd.tab_rd_slot = 1'b1;
                state_next = ST_FIN_WR;
            end
            ST_FIN_WR:
            begin
                cmd.fin_wr = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next = ST_FIN_SRD;
            end
            ST_RESULT:
            begin
                cmd.emit_block = 1'b1;
                cmd.clear_block = 1'b1;
                state_next = ST_IDLE;
            end
            ST_READ_OUT:
            begin
                cmd.emit_read = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_fin_walk_writes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN_TRD |=> state_reg == ST_FIN_WR)
        else $error("finish walk skipped the table write");
    a_result_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_block || cmd.emit_read || cmd.emit_empty) |=> state_reg == ST_IDLE)
        else $error("controller did not return to idle after a result");
    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> state_reg == ST_IDLE)
        else $error("item accepted while busy");

endmodule

/* src/poc_dp.sv */
// Datapath with the cache table, the seen list, block counters and the result register.
module poc_dp
    import poc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   in_item,
    input  logic       cfg_we,
    input  logic [9:0] cfg_wdata,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic       done,
    output result_t    result
);

    table_entry_t table_mem [TABLE_DEPTH];
    seen_entry_t  seen_mem [SEEN_DEPTH];

    in_item_t          item_reg;
    table_entry_t      tab_rdata_reg;
    seen_entry_t       seen_rdata_reg;
    logic [9:0]        limit_reg;
    logic [TAB_CW-1:0] table_fill_reg;
    logic [SEEN_CW-1:0] seen_fill_reg;
    logic [TAB_CW-1:0] idx_reg;
    logic [TAB_AW-1:0] new_slot_reg;
    logic [BLK_CW-1:0] used_reg;
    logic [BLK_CW-1:0] free_reg;
    logic [BLK_CW-1:0] nonslab_reg;
    logic              valid_reg;
    logic              hostage_reg;
    logic              movable_reg;
    logic              done_reg;
    result_t           result_reg;

    logic              tab_we;
    logic [TAB_AW-1:0] tab_waddr;
    table_entry_t      tab_wdata;
    logic              tab_re;
    logic [TAB_AW-1:0] tab_raddr;
    logic              seen_we;
    logic [SEEN_AW-1:0] seen_waddr;
    seen_entry_t       seen_wdata;
    logic [40:0]       pages_sum;
    logic [40:0]       hpages_sum;
    logic [32:0]       blocks_sum;
    logic [32:0]       hblocks_sum;
    logic [32:0]       solo_sum;
    logic              hostage_now;
    result_t           block_res;
    result_t           read_res;

    assign status.is_page = (item_reg.operation == OP_PAGE);
    assign status.is_read = (item_reg.operation == OP_READ);
    assign status.is_clear = (item_reg.operation == OP_CLEAR);
    assign status.is_slab = (item_reg.page_kind == KIND_SLAB);
    assign status.block_end = item_reg.block_end;
    assign status.seen_end = (idx_reg == TAB_CW'(seen_fill_reg));
    assign status.seen_full = (seen_fill_reg >= SEEN_CW'(SEEN_DEPTH));
    assign status.seen_hit = (seen_rdata_reg.key == item_reg.owner_key);
    assign status.tab_end = (idx_reg == table_fill_reg);
    assign status.tab_full = (table_fill_reg >= TAB_CW'(TABLE_DEPTH));
    assign status.tab_hit = (tab_rdata_reg.key == item_reg.owner_key);
    assign status.block_valid = valid_reg;
    assign status.read_ok = (TAB_CW'(item_reg.entry_index) < table_fill_reg);

    assign hostage_now = (used_reg != '0) && (10'(used_reg) <= limit_reg);

    assign pages_sum = {1'b0, tab_rdata_reg.pages} + 41'(seen_rdata_reg.count);
    assign hpages_sum = {1'b0, tab_rdata_reg.hpages} + 41'(seen_rdata_reg.count);
    assign blocks_sum = {1'b0, tab_rdata_reg.blocks} + 33'd1;
    assign hblocks_sum = {1'b0, tab_rdata_reg.hblocks} + 33'd1;
    assign solo_sum = {1'b0, tab_rdata_reg.lone} + 33'd1;

    always_comb
    begin
        tab_we = 1'b0;
        tab_waddr = table_fill_reg[TAB_AW-1:0];
        tab_wdata = tab_rdata_reg;
        if (cmd.tab_new)
        begin
            tab_we = 1'b1;
            tab_wdata = '0;
            tab_wdata.key = item_reg.owner_key;
            tab_wdata.mobile = item_reg.owner_mobile;
        end
        else if (cmd.fin_wr)
        begin
            tab_we = 1'b1;
            tab_waddr = seen_rdata_reg.slot;
            tab_wdata.pages = pages_sum[40] ? '1 : pages_sum[39:0];
            tab_wdata.blocks = blocks_sum[32] ? '1 : blocks_sum[31:0];
            if (hostage_reg)
            begin
                tab_wdata.hpages = hpages_sum[40] ? '1 : hpages_sum[39:0];
                tab_wdata.hblocks = hblocks_sum[32] ? '1 : hblocks_sum[31:0];
                if (seen_fill_reg == SEEN_CW'(1) && nonslab_reg == '0)
                    tab_wdata.lone = solo_sum[32] ? '1 : solo_sum[31:0];
            end
        end
    end

    always_comb
    begin
        tab_re = cmd.tab_rd_idx || cmd.tab_rd_slot || cmd.tab_rd_read;
        if (cmd.tab_rd_slot)
            tab_raddr = seen_rdata_reg.slot;
        else if (cmd.tab_rd_read)
            tab_raddr = item_reg.entry_index[TAB_AW-1:0];
        else
            tab_raddr = idx_reg[TAB_AW-1:0];
    end

    always_comb
    begin
        seen_we = 1'b0;
        seen_waddr = idx_reg[SEEN_AW-1:0];
        seen_wdata = seen_rdata_reg;
        if (cmd.seen_bump)
        begin
            seen_we = 1'b1;
            seen_wdata.count = sat_inc(seen_rdata_reg.count);
        end
        else if (cmd.seen_add)
        begin
            seen_we = 1'b1;
            seen_waddr = seen_fill_reg[SEEN_AW-1:0];
            seen_wdata.key = item_reg.owner_key;
            seen_wdata.slot = new_slot_reg;
            seen_wdata.count = BLK_CW'(1);
        end
    end

    always_comb
    begin
        block_res = '0;
        block_res.present = 1'b1;
        block_res.page_total = 40'(used_reg);
        block_res.free_total = 10'(free_reg);
        if (hostage_reg)
        begin
            block_res.is_hostage = 1'b1;
            if (nonslab_reg != '0)
                block_res.obstacle = OBST_NONSLAB;
            else if (movable_reg)
                block_res.obstacle = OBST_MOBILE;
            else
                block_res.obstacle = OBST_SLAB;
            if (nonslab_reg != '0 || seen_fill_reg > SEEN_CW'(2))
                block_res.pin_class = PIN_MANY;
            else if (seen_fill_reg == SEEN_CW'(2))
                block_res.pin_class = PIN_TWO;
            else
                block_res.pin_class = PIN_ONE;
        end
        else
        begin
            block_res.pin_class = PIN_NONE;
        end
    end

    always_comb
    begin
        read_res = '0;
        read_res.present = 1'b1;
        read_res.entry_key = tab_rdata_reg.key;
        read_res.page_total = tab_rdata_reg.pages;
        read_res.block_count = tab_rdata_reg.blocks;
        read_res.hostage_page_count = tab_rdata_reg.hpages;
        read_res.hostage_block_count = tab_rdata_reg.hblocks;
        read_res.solo_block_count = tab_rdata_reg.lone;
        read_res.entry_mobile = tab_rdata_reg.mobile;
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
            table_mem[tab_waddr] <= tab_wdata;
        if (tab_re)
            tab_rdata_reg <= table_mem[tab_raddr];
        if (seen_we)
            seen_mem[seen_waddr] <= seen_wdata;
        if (cmd.seen_rd)
            seen_rdata_reg <= seen_mem[idx_reg[SEEN_AW-1:0]];
        if (cmd.accept)
            item_reg <= in_item;
        if (cmd.tab_new)
            new_slot_reg <= table_fill_reg[TAB_AW-1:0];
        else if (cmd.tab_found)
            new_slot_reg <= idx_reg[TAB_AW-1:0];
        if (cmd.emit_block)
            result_reg <= block_res;
        else if (cmd.emit_read)
            result_reg <= read_res;
        else if (cmd.emit_empty)
            result_reg <= '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            table_fill_reg <= '0;
            seen_fill_reg <= '0;
            idx_reg <= '0;
            used_reg <= '0;
            free_reg <= '0;
            nonslab_reg <= '0;
            valid_reg <= 1'b0;
            hostage_reg <= 1'b0;
            movable_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit_block || cmd.emit_read || cmd.emit_empty;
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.clear_table)
                table_fill_reg <= '0;
            else if (cmd.tab_new)
                table_fill_reg <= table_fill_reg + 1'b1;
            if (cmd.fin_start)
            begin
                hostage_reg <= hostage_now;
                movable_reg <= 1'b1;
            end
            else if (cmd.fin_wr && hostage_reg && !tab_rdata_reg.mobile)
                movable_reg <= 1'b0;
            if (cmd.clear_block)
            begin
                seen_fill_reg <= '0;
                used_reg <= '0;
                free_reg <= '0;
                nonslab_reg <= '0;
                valid_reg <= 1'b0;
            end
            else
            begin
                if (cmd.seen_add)
                    seen_fill_reg <= seen_fill_reg + 1'b1;
                if (cmd.count_page)
                begin
                    case (item_reg.page_kind)
                        KIND_FREE:
                        begin
                            valid_reg <= 1'b1;
                            free_reg <= sat_inc(free_reg);
                        end
                        KIND_LRU, KIND_SLAB:
                        begin
                            valid_reg <= 1'b1;
                            used_reg <= sat_inc(used_reg);
                        end
                        KIND_NONLRU:
                        begin
                            valid_reg <= 1'b1;
                            used_reg <= sat_inc(used_reg);
                            nonslab_reg <= sat_inc(nonslab_reg);
                        end
                        default:
                        begin
                            valid_reg <= valid_reg;
                        end
                    endcase
                end
            end
        end
    end

    assign done = done_reg;
    assign result = result_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");
    a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.clear_table |=> table_fill_reg >= $past(table_fill_reg))
        else $error("table fill shrank without a clear");
    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.seen_add |-> seen_fill_reg < SEEN_CW'(SEEN_DEPTH))
        else $error("seen list overflow");

endmodule

/* verif/tb_pageblock_occupancy_classifier.sv */
// Self-checking testbench for the pageblock occupancy classifier.
`timescale 1ns / 1ps

module tb;
    import poc_pkg::*;

    localparam int  LIMIT_CYCLES = 20000000;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic [2:0] KIND_INVALID = 3'd0;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    in_item_t   in_item = '0;
    logic       cfg_we = 1'b0;
    logic [9:0] cfg_wdata = '0;
    logic       done;
    result_t    result;

    pageblock_occupancy_classifier dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result)
    );

    always #6 clk = ~clk;

    logic [15:0] tab_key [TABLE_DEPTH];
    logic [39:0] tab_pages [TABLE_DEPTH];
    logic [31:0] tab_blocks [TABLE_DEPTH];
    logic [39:0] tab_hpages [TABLE_DEPTH];
    logic [31:0] tab_hblocks [TABLE_DEPTH];
    logic [31:0] tab_solo [TABLE_DEPTH];
    logic        tab_mobile [TABLE_DEPTH];
    int          tab_fill;
    int          seen_slot [SEEN_DEPTH];
    int          seen_cnt [SEEN_DEPTH];
    int          seen_fill;
    int          blk_used, blk_free, blk_nonslab;
    bit          blk_valid;
    logic [9:0]  hostage_limit;

    result_t     expected_results [$];
    int          errors, checked, cycles, items_sent, blocks_sent, reads_sent;
    bit          quiet;

    function automatic int page_inc(input int v);
        return (v >= BLOCK_PAGES) ? BLOCK_PAGES : v + 1;
    endfunction

    function automatic logic [39:0] add40(input logic [39:0] a, input int b);
        logic [40:0] s;
        s = {1'b0, a} + 41'(b);
        return s[40] ? '1 : s[39:0];
    endfunction

    function automatic logic [31:0] inc32(input logic [31:0] a);
        return (a == '1) ? a : a + 1'b1;
    endfunction

    task automatic drop_block();
        blk_used = 0;
        blk_free = 0;
        blk_nonslab = 0;
        blk_valid = 0;
        seen_fill = 0;
    endtask

    task automatic count_slab(input logic [15:0] key, input logic mobile);
        int i, t;
        for (i = 0; i < seen_fill; i++)
            if (tab_key[seen_slot[i]] == key) break;
        if (i == seen_fill) begin
            if (seen_fill >= SEEN_DEPTH) return;
            for (t = 0; t < tab_fill; t++)
                if (tab_key[t] == key) break;
            if (t == tab_fill) begin
                if (tab_fill >= TABLE_DEPTH) return;
                tab_key[t] = key;
                tab_pages[t] = '0;
                tab_blocks[t] = '0;
                tab_hpages[t] = '0;
                tab_hblocks[t] = '0;
                tab_solo[t] = '0;
                tab_mobile[t] = mobile;
                tab_fill++;
            end
            seen_slot[i] = t;
            seen_cnt[i] = 0;
            seen_fill++;
        end
        seen_cnt[i] = page_inc(seen_cnt[i]);
    endtask

    function automatic result_t classify_block();
        result_t r;
        bit hostage, movable;
        int i, t;
        r = '0;
        movable = 1;
        if (!blk_valid) return r;
        hostage = blk_used != 0 && blk_used <= int'(hostage_limit);
        for (i = 0; i < seen_fill; i++) begin
            t = seen_slot[i];
            tab_pages[t] = add40(tab_pages[t], seen_cnt[i]);
            tab_blocks[t] = inc32(tab_blocks[t]);
            if (hostage) begin
                tab_hpages[t] = add40(tab_hpages[t], seen_cnt[i]);
                tab_hblocks[t] = inc32(tab_hblocks[t]);
                if (!tab_mobile[t]) movable = 0;
            end
        end
        r.present = 1'b1;
        r.page_total = 40'(blk_used);
        r.free_total = 10'(blk_free);
        if (!hostage) return r;
        r.is_hostage = 1'b1;
        if (blk_nonslab != 0) r.obstacle = OBST_NONSLAB;
        else if (movable) r.obstacle = OBST_MOBILE;
        else r.obstacle = OBST_SLAB;
        if (seen_fill == 1 && blk_nonslab == 0)
            tab_solo[seen_slot[0]] = inc32(tab_solo[seen_slot[0]]);
        if (blk_nonslab != 0 || seen_fill > 2) r.pin_class = PIN_MANY;
        else if (seen_fill == 2) r.pin_class = PIN_TWO;
        else r.pin_class = PIN_ONE;
        return r;
    endfunction

    task automatic predict_item(input in_item_t it);
        result_t r;
        r = '0;
        if (it.operation == OP_PAGE) begin
            case (it.page_kind)
                KIND_FREE: begin
                    blk_valid = 1;
                    blk_free = page_inc(blk_free);
                end
                KIND_LRU: begin
                    blk_valid = 1;
                    blk_used = page_inc(blk_used);
                end
                KIND_NONLRU: begin
                    blk_valid = 1;
                    blk_used = page_inc(blk_used);
                    blk_nonslab = page_inc(blk_nonslab);
                end
                KIND_SLAB: begin
                    blk_valid = 1;
                    blk_used = page_inc(blk_used);
                    count_slab(it.owner_key, it.owner_mobile);
                end
                default: ;
            endcase
            if (it.block_end) begin
                expected_results.push_back(classify_block());
                drop_block();
            end
        end else if (it.operation == OP_READ) begin
            if (int'(it.entry_index) < tab_fill) begin
                r.present = 1'b1;
                r.entry_key = tab_key[it.entry_index];
                r.page_total = tab_pages[it.entry_index];
                r.block_count = tab_blocks[it.entry_index];
                r.hostage_page_count = tab_hpages[it.entry_index];
                r.hostage_block_count = tab_hblocks[it.entry_index];
                r.solo_block_count = tab_solo[it.entry_index];
                r.entry_mobile = tab_mobile[it.entry_index];
            end
            expected_results.push_back(r);
        end else if (it.operation == OP_CLEAR) begin
            tab_fill = 0;
            drop_block();
        end
    endtask

    function automatic in_item_t mk(input logic [1:0] op, input logic [2:0] kind,
                                    input logic [15:0] key, input logic mob,
                                    input logic last, input logic [8:0] idx);
        in_item_t it;
        it.operation = op;
        it.page_kind = kind;
        it.owner_key = key;
        it.owner_mobile = mob;
        it.block_end = last;
        it.entry_index = idx;
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        int gap;
        start <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (busy);
        predict_item(it);
        items_sent++;
        if (it.operation == OP_PAGE && it.block_end) blocks_sent++;
        if (it.operation == OP_READ) reads_sent++;
        gap = quiet ? 0 : (($urandom_range(0, 9) < 3) ? $urandom_range(1, 17) : 0);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        repeat (2) @(posedge clk);
        while (expected_results.size() != 0 || busy) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_limit(input logic [9:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        hostage_limit = v;
    endtask

    task automatic send_block(input int n, input int pool, input logic [15:0] base,
                              input bit slab_only);
        int i, k;
        logic [2:0] kind;
        for (i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (slab_only) kind = (k < 90) ? KIND_SLAB : KIND_FREE;
            else if (k < 12) kind = KIND_FREE;
            else if (k < 35) kind = KIND_LRU;
            else if (k < 45) kind = KIND_NONLRU;
            else if (k < 94) kind = KIND_SLAB;
            else kind = 3'($urandom_range(5, 7)) & ((k < 97) ? 3'd0 : 3'd7);
            send_item(mk(OP_PAGE, kind, base + 16'($urandom_range(0, pool - 1)),
                         1'($urandom), i == n - 1, 9'($urandom)));
        end
    endtask

    task automatic test_directed();
        send_item(mk(OP_READ, KIND_INVALID, 16'h0, 1'b0, 1'b0, 9'd0));
        send_item(mk(OP_PAGE, KIND_INVALID, 16'hFFFF, 1'b1, 1'b1, 9'h1FF));
        send_item(mk(OP_NONE, KIND_SLAB, 16'h1234, 1'b1, 1'b1, 9'd3));
        send_item(mk(OP_PAGE, 3'd7, 16'h0, 1'b0, 1'b1, 9'd0));
        send_item(mk(OP_PAGE, KIND_SLAB, 16'hFFFF, 1'b1, 1'b1, 9'd0));
        send_item(mk(OP_PAGE, KIND_SLAB, 16'h0000, 1'b0, 1'b0, 9'd0));
        send_item(mk(OP_PAGE, KIND_SLAB, 16'hFFFF, 1'b0, 1'b0, 9'd0));
        send_item(mk(OP_PAGE, KIND_FREE, 16'h0, 1'b0, 1'b1, 9'd0));
        send_item(mk(OP_PAGE, KIND_NONLRU, 16'h0, 1'b0, 1'b0, 9'd0));
        send_item(mk(OP_PAGE, KIND_SLAB, 16'h5A5A, 1'b1, 1'b0, 9'd0));
        send_item(mk(OP_PAGE, KIND_LRU, 16'h0, 1'b0, 1'b1, 9'd0));
        send_item(mk(OP_PAGE, KIND_FREE, 16'h0, 1'b0, 1'b0, 9'd0));
        send_item(mk(OP_PAGE, KIND_FREE, 16'h0, 1'b0, 1'b1, 9'd0));
        send_item(mk(OP_READ, KIND_INVALID, 16'h0, 1'b0, 1'b0, 9'd0));
        send_item(mk(OP_READ, KIND_INVALID, 16'h0, 1'b0, 1'b0, 9'd1));
        send_item(mk(OP_READ, KIND_INVALID, 16'h0, 1'b0, 1'b0, 9'd2));
        send_item(mk(OP_READ, KIND_INVALID, 16'h0, 1'b0, 1'b0, 9'h1FF));
        send_item(mk(OP_PAGE, KIND_SLAB, 16'h0001, 1'b1, 1'b0, 9'd0));
        send_item(mk(OP_CLEAR, KIND_INVALID, 16'h0, 1'b0, 1'b0, 9'd0));
        send_item(mk(OP_READ, KIND_INVALID, 16'h0, 1'b0, 1'b0, 9'd0));
        send_item(mk(OP_PAGE, KIND_LRU, 16'h0, 1'b0, 1'b1, 9'd0));
    endtask

    task automatic test_long_block();
        send_block(600, 3, 16'h0100, 1'b0);
        send_item(mk(OP_READ, KIND_INVALID, 16'h0, 1'b0, 1'b0, 9'd0));
    endtask

    task automatic test_seen_overflow();
        int i;
        send_item(mk(OP_CLEAR, KIND_INVALID, 16'h0, 1'b0, 1'b0, 9'd0));
        for (i = 0; i < SEEN_DEPTH + 6; i++)
            send_item(mk(OP_PAGE, KIND_SLAB, 16'(16'h2000 + i), 1'($urandom),
                         i == SEEN_DEPTH + 5, 9'd0));
        for (i = SEEN_DEPTH - 2; i < SEEN_DEPTH + 2; i++)
            send_item(mk(OP_READ, KIND_INVALID, 16'h0, 1'b0, 1'b0, 9'(i)));
    endtask

    task automatic test_table_overflow();
        int i;
        send_item(mk(OP_CLEAR, KIND_INVALID, 16'h0, 1'b0, 1'b0, 9'd0));
        for (i = 0; i < TABLE_DEPTH + 8; i++)
            send_item(mk(OP_PAGE, KIND_SLAB, 16'(16'h8000 + 7 * i), 1'($urandom),
                         (i % 32) == 31 || i == TABLE_DEPTH + 7, 9'd0));
        send_item(mk(OP_READ, KIND_INVALID, 16'h0, 1'b0, 1'b0, 9'd0));
        send_item(mk(OP_READ, KIND_INVALID, 16'h0, 1'b0, 1'b0, 9'h1FF));
        send_item(mk(OP_CLEAR, KIND_INVALID, 16'h0, 1'b0, 1'b0, 9'd0));
    endtask

    task automatic test_random(input int target);
        int k, base;
        base = items_sent;
        while (items_sent - base < target) begin
            k = $urandom_range(0, 99);
            if (k < 78)
                send_block(($urandom_range(0, 49) == 0) ? $urandom_range(25, 560)
                                                       : $urandom_range(1, 24),
                           $urandom_range(1, 4), 16'($urandom_range(0, 40)),
                           $urandom_range(0, 9) < 4);
            else if (k < 90)
                send_item(mk(OP_READ, 3'($urandom), 16'($urandom), 1'($urandom),
                             1'($urandom), ($urandom_range(0, 3) == 0) ? 9'($urandom)
                             : 9'($urandom_range(0, tab_fill + 1))));
            else if (k < 93)
                send_item(mk(OP_CLEAR, 3'($urandom), 16'($urandom), 1'($urandom),
                             1'($urandom), 9'($urandom)));
            else
                send_item(mk(2'($urandom), 3'($urandom), 16'($urandom), 1'($urandom),
                             1'($urandom), 9'($urandom)));
        end
        send_item(mk(OP_CLEAR, KIND_INVALID, 16'h0, 1'b0, 1'b0, 9'd0));
    endtask

    task automatic report(input string name, input logic [63:0] e, input logic [63:0] a);
        if (e !== a) begin
            $error("%s expected %0h actual %0h", name, e, a);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        result_t e;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                $error("result with no item pending");
                errors++;
            end else begin
                e = expected_results.pop_front();
                checked++;
                report("present", 64'(e.present), 64'(result.present));
                report("entry_key", 64'(e.entry_key), 64'(result.entry_key));
                report("page_total", 64'(e.page_total), 64'(result.page_total));
                report("free_total", 64'(e.free_total), 64'(result.free_total));
                report("is_hostage", 64'(e.is_hostage), 64'(result.is_hostage));
                report("pin_class", 64'(e.pin_class), 64'(result.pin_class));
                report("obstacle", 64'(e.obstacle), 64'(result.obstacle));
                report("block_count", 64'(e.block_count), 64'(result.block_count));
                report("hostage_page_count", 64'(e.hostage_page_count),
                       64'(result.hostage_page_count));
                report("hostage_block_count", 64'(e.hostage_block_count),
                       64'(result.hostage_block_count));
                report("solo_block_count", 64'(e.solo_block_count),
                       64'(result.solo_block_count));
                report("entry_mobile", 64'(e.entry_mobile), 64'(result.entry_mobile));
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        errors = 0;
        checked = 0;
        cycles = 0;
        items_sent = 0;
        blocks_sent = 0;
        reads_sent = 0;
        quiet = 0;
        tab_fill = 0;
        drop_block();
        hostage_limit = LIMIT_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        set_limit(10'd0);
        test_random(40);
        set_limit(10'd512);
        test_long_block();
        test_seen_overflow();
        set_limit(10'd2);
        test_random(100);
        set_limit(10'd64);
        test_table_overflow();
        set_limit(10'($urandom_range(1, 40)));
        test_random(150);
        set_limit(10'd5);
        test_random(100);
        quiet = 1;
        set_limit(10'd512);
        test_random(40);
        wait_idle();

        $display("Sent %0d items: %0d pageblocks and %0d table reads.",
                 items_sent, blocks_sent, reads_sent);
        $display("Checked %0d results with %0d mismatches.", checked, errors);
        if (errors == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
src/poc_pkg.sv
src/poc_ctrl.sv
src/poc_dp.sv
src/pageblock_occupancy_classifier.sv
verif/tb_pageblock_occupancy_classifier.sv
